/* rtl/rbhs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbhs_pkg: shared types and constants for the red/black heat stencil
// Payload types of the channels, configuration register codes and reset
// values, and the constants of the divide-by-five datapath.
// ----------------------------------------------------------------------------
package rbhs_pkg;

	// payload types
	typedef logic signed [31:0] cell_t;
	typedef logic [5:0]         col_t;
	typedef logic [15:0]        row_t;
	typedef logic [47:0]        csum_t;
	typedef logic [1:0]         cfg_index_t;
	typedef logic [15:0]        cfg_data_t;

	// configuration register codes
	localparam cfg_index_t REG_GRID_WIDTH  = 2'd0;
	localparam cfg_index_t REG_GRID_HEIGHT = 2'd1;
	localparam cfg_index_t REG_RED_PASS    = 2'd2;

	// register reset values
	localparam logic [6:0]  GRID_WIDTH_RST  = 7'd64;
	localparam logic [15:0] GRID_HEIGHT_RST = 16'd64;
	localparam logic        RED_PASS_RST    = 1'b1;

	// smallest grid side: one interior cell between two boundaries
	localparam int MIN_DIM = 3;

	// divide by five: u = a * 2^18 + b, 2^18 = 5 * 52428 + 4
	// so u / 5 = 52428 * a + (4 * a + b) / 5, the small part by reciprocal
	localparam int          DIV5_SPLIT    = 18;
	localparam logic [15:0] DIV5_HI_MUL   = 16'd52428;
	localparam logic [20:0] DIV5_LO_MUL   = 21'd1677722;
	localparam int          DIV5_LO_SHIFT = 23;

	// update tag that travels with each item through the datapath
	typedef struct packed {
		col_t column;
		row_t row;
		logic active;
		logic last;
		logic frame_start;
	} tag_t;

	// one emitted cell with its four neighbours
	typedef struct packed {
		cell_t mid;
		cell_t up;
		cell_t down;
		cell_t left;
		cell_t right;
		tag_t  tag;
	} stencil_item_t;

endpackage

/* rtl/rbhs_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbhs_in_if: input cell channel
// Valid/ready channel carrying one grid cell in raster order.
// ----------------------------------------------------------------------------
interface rbhs_in_if import rbhs_pkg::*; ();

	logic  valid;
	logic  ready;
	cell_t cell_in;

	modport source (output valid, output cell_in, input ready);
	modport sink (input valid, input cell_in, output ready);

endinterface

/* rtl/rbhs_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbhs_out_if: result cell channel
// Valid/ready channel carrying one emitted cell with its position and the
// running change sum of the frame.
// ----------------------------------------------------------------------------
interface rbhs_out_if import rbhs_pkg::*; ();

	logic  valid;
	logic  ready;
	cell_t cell_out;
	col_t  out_column;
	row_t  out_row;
	csum_t change_sum;
	logic  frame_done;

	modport source (
		output valid, output cell_out, output out_column, output out_row,
		output change_sum, output frame_done, input ready
	);
	modport sink (
		input valid, input cell_out, input out_column, input out_row,
		input change_sum, input frame_done, output ready
	);

endinterface

/* rtl/rbhs_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbhs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface rbhs_cfg_if import rbhs_pkg::*; ();

	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);

endinterface

/* rtl/rbhs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbhs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rbhs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/rbhs_update_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbhs_update_pipe: stencil update datapath
// Five-point average rounded to nearest, absolute change and the saturating
// per-frame change sum, in five register stages plus the output register.
// Each stage holds only while the next is full and cannot move on, so bubbles close up.
// ----------------------------------------------------------------------------
module rbhs_update_pipe import rbhs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  stencil_item_t      item,
	rbhs_out_if.source         dout
);

	// offset-binary form of a cell: v + 2^31 as an unsigned value
	function automatic logic [34:0] offset35(cell_t v);
		return 35'({~v[31], v[30:0]});
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic go1, go2, go3, go4, go5, go_out;

	stencil_item_t item_s1;
	logic [34:0]   u_s2;
	cell_t         old_s2, old_s3, old_s4, new_s4, new_s5;
	tag_t          tag_s2, tag_s3, tag_s4, tag_s5;
	logic [32:0]   prod_a_s3;
	logic [40:0]   prod_t_s3;
	logic [31:0]   absd_s5;

	cell_t         cell_out_q;
	col_t          column_q;
	row_t          row_q;
	logic          last_q;
	csum_t         acc_q;

	logic [34:0]   u_sum;
	logic [16:0]   a_part;
	logic [17:0]   b_part;
	logic [19:0]   t_part;
	logic [32:0]   q_sum;
	logic [31:0]   q_cell;
	logic [32:0]   diff;
	logic [32:0]   diff_neg;
	logic [31:0]   absd;
	csum_t         acc_base;
	logic [48:0]   acc_sum;
	csum_t         acc_next;

	// stage advance: a stage loads when empty or when its item moves on
	assign go_out     = !out_valid_q || dout.ready;
	assign go5        = !v_s5 || go_out;
	assign go4        = !v_s4 || go5;
	assign go3        = !v_s3 || go4;
	assign go2        = !v_s2 || go3;
	assign go1        = !v_s1 || go2;
	assign item_ready = go1;

	// sum of five cells plus rounding bias, all in offset binary
	assign u_sum = offset35(item_s1.mid) + offset35(item_s1.up) + offset35(item_s1.down)
		+ offset35(item_s1.left) + offset35(item_s1.right) + 35'd2;

	// split for the divide by five
	assign a_part = u_s2[34:DIV5_SPLIT];
	assign b_part = u_s2[DIV5_SPLIT-1:0];
	assign t_part = 20'({a_part, 2'b00}) + 20'(b_part);

	// quotient back to two's complement
	assign q_sum  = prod_a_s3 + 33'(prod_t_s3 >> DIV5_LO_SHIFT);
	assign q_cell = {~q_sum[31], q_sum[30:0]};

	// absolute change
	assign diff     = {old_s4[31], old_s4} - {new_s4[31], new_s4};
	assign diff_neg = -diff;
	assign absd     = diff[32] ? diff_neg[31:0] : diff[31:0];

	// saturating frame accumulator
	assign acc_base = tag_s5.frame_start ? '0 : acc_q;
	assign acc_sum  = {1'b0, acc_base} + 49'(absd_s5);
	assign acc_next = acc_sum[48] ? '1 : acc_sum[47:0];

	// stage valid bits and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			if (go1) begin
				v_s1 <= item_valid;
			end
			if (go2) begin
				v_s2 <= v_s1;
			end
			if (go3) begin
				v_s3 <= v_s2;
			end
			if (go4) begin
				v_s4 <= v_s3;
			end
			if (go5) begin
				v_s5 <= v_s4;
			end
			if (go_out) begin
				out_valid_q <= v_s5;
			end
			if (go_out && v_s5) begin
				acc_q <= acc_next;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (go1) begin
			item_s1 <= item;
		end
		if (go2) begin
			u_s2   <= u_sum;
			old_s2 <= item_s1.mid;
			tag_s2 <= item_s1.tag;
		end
		if (go3) begin
			prod_a_s3 <= 33'(a_part) * 33'(DIV5_HI_MUL);
			prod_t_s3 <= 41'(t_part) * 41'(DIV5_LO_MUL);
			old_s3    <= old_s2;
			tag_s3    <= tag_s2;
		end
		if (go4) begin
			new_s4 <= tag_s3.active ? cell_t'(q_cell) : old_s3;
			old_s4 <= old_s3;
			tag_s4 <= tag_s3;
		end
		if (go5) begin
			new_s5  <= new_s4;
			absd_s5 <= absd;
			tag_s5  <= tag_s4;
		end
		if (go_out && v_s5) begin
			cell_out_q <= new_s5;
			column_q   <= tag_s5.column;
			row_q      <= tag_s5.row;
			last_q     <= tag_s5.last;
		end
	end

	// result channel
	assign dout.valid      = out_valid_q;
	assign dout.cell_out   = cell_out_q;
	assign dout.out_column = column_q;
	assign dout.out_row    = row_q;
	assign dout.change_sum = acc_q;
	assign dout.frame_done = last_q;

`ifndef NO_ASSERTIONS
	// a stalled last stage keeps its item
	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !go_out |=> v_s5)
		else $error("rbhs_update_pipe: item dropped from last stage under stall");

	// a cell that is not updated adds nothing to the change sum
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !tag_s5.active |-> absd_s5 == '0)
		else $error("rbhs_update_pipe: change on a pass-through cell");

	// within a frame the change sum never falls
	a_acc_mono: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && go_out && !tag_s5.frame_start |=> acc_q >= $past(acc_q))
		else $error("rbhs_update_pipe: change sum decreased within a frame");
`endif

endmodule

/* rtl/red_black_heat_stencil.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_black_heat_stencil: streaming red/black half-sweep of a heat stencil
// Line buffers, raster position tracking and configuration; the update
// arithmetic lives in rbhs_update_pipe.
// ----------------------------------------------------------------------------
// Cells enter in raster order, one per cycle unless dout stalls; the cell
// at (x,y) with y >= 1 yields the cell at (x,y-1) via the pipe stages and
// output register, while cells of row zero yield nothing. Throughput is
// set by the line buffers: each takes one write per accepted cell and its
// registered read is issued ahead at the next column, so no cycle is lost
// at row ends. Buffers start undefined and need no clearing pass; write a
// full top row and the row below it before relying on results. Config is
// taken on any cycle but must only change while no item is in flight.
// ----------------------------------------------------------------------------
module red_black_heat_stencil import rbhs_pkg::*; #(
	parameter int MAX_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	rbhs_cfg_if.sink    cfg,
	rbhs_in_if.sink     din,
	rbhs_out_if.source  dout
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW0 = $clog2(MAX_WIDTH + 1);
	localparam int WW  = (WW0 > 7) ? WW0 : 7;
	localparam int WX  = WW + 1;

	logic [6:0]    grid_width_q;
	logic [15:0]   grid_height_q;
	logic          red_pass_q;
	logic [CW-1:0] column_pos_q;
	row_t          row_pos_q;
	logic          clr_pend_q;
	cell_t         left_above_q;

	logic [WW-1:0] gw;
	logic [WW-1:0] w_eff;
	row_t          h_eff;
	logic [WX-1:0] xe;
	logic [WX-1:0] we;
	logic [16:0]   ye;
	logic [16:0]   he;
	row_t          r;
	logic          last_col;
	logic          last_row;
	logic          x_fit;
	logic          r_fit;
	logic          active;
	logic          emit;
	logic          accept;
	logic [CW-1:0] col_next;
	row_t          row_next;
	logic [CW-1:0] rd_addr;
	logic [CW-1:0] right_addr;
	cell_t         mid_rd;
	cell_t         up_rd;
	cell_t         right_rd;
	logic          item_valid;
	logic          item_ready;
	stencil_item_t item;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			red_pass_q    <= RED_PASS_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg.wdata[6:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg.wdata;
				REG_RED_PASS:    red_pass_q    <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// effective grid size
	assign gw = WW'(grid_width_q);

	always_comb begin
		if (gw < WW'(MIN_DIM)) begin
			w_eff = WW'(MIN_DIM);
		end else if (gw > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = gw;
		end
	end

	assign h_eff = (grid_height_q < row_t'(MIN_DIM)) ? row_t'(MIN_DIM) : grid_height_q;

	// position classification
	assign xe       = WX'(column_pos_q);
	assign we       = WX'(w_eff);
	assign ye       = 17'(row_pos_q);
	assign he       = 17'(h_eff);
	assign r        = row_pos_q - 16'd1;
	assign last_col = (xe + WX'(1)) >= we;
	assign last_row = (ye + 17'd1) >= he;
	assign x_fit    = (column_pos_q != '0) && ((xe + WX'(2)) <= we);
	assign r_fit    = (r != '0) && ((17'(r) + 17'd2) <= he);
	assign active   = x_fit && r_fit && ((column_pos_q[0] ^ r[0]) == red_pass_q);
	assign emit     = (row_pos_q != '0);

	// handshake: cells of row zero only fill the buffers
	assign din.ready  = !emit || item_ready;
	assign accept     = din.valid && din.ready;
	assign item_valid = din.valid && emit;

	// next raster position
	assign col_next = last_col ? '0 : column_pos_q + CW'(1);
	assign row_next = last_col ? (last_row ? '0 : row_pos_q + 16'd1) : row_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_pos_q <= '0;
			row_pos_q    <= '0;
			clr_pend_q   <= 1'b0;
		end else if (accept) begin
			column_pos_q <= col_next;
			row_pos_q    <= row_next;
			if (column_pos_q == '0 && row_pos_q == '0) begin
				clr_pend_q <= 1'b1;
			end else if (emit) begin
				clr_pend_q <= 1'b0;
			end
		end
	end

	// previous-row cell left of the current column
	always_ff @(posedge clk) begin
		if (accept) begin
			left_above_q <= mid_rd;
		end
	end

	// read ahead: the next column once this cell is taken
	assign rd_addr    = accept ? col_next : column_pos_q;
	assign right_addr = (rd_addr == CW'(MAX_WIDTH - 1)) ? '0 : rd_addr + CW'(1);

	// row one back, read at the current column
	rbhs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_row_one_mid (
		.clk   (clk),
		.we    (accept),
		.waddr (column_pos_q),
		.wdata (din.cell_in),
		.raddr (rd_addr),
		.rdata (mid_rd)
	);

	// copy of row one back, read one column to the right
	rbhs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_row_one_right (
		.clk   (clk),
		.we    (accept),
		.waddr (column_pos_q),
		.wdata (din.cell_in),
		.raddr (right_addr),
		.rdata (right_rd)
	);

	// row two back
	rbhs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_row_two (
		.clk   (clk),
		.we    (accept),
		.waddr (column_pos_q),
		.wdata (mid_rd),
		.raddr (rd_addr),
		.rdata (up_rd)
	);

	// stencil item for the update datapath
	assign item.mid             = mid_rd;
	assign item.up              = up_rd;
	assign item.down            = din.cell_in;
	assign item.left            = left_above_q;
	assign item.right           = right_rd;
	assign item.tag.column      = col_t'(column_pos_q);
	assign item.tag.row         = r;
	assign item.tag.active      = active;
	assign item.tag.last        = last_col && last_row;
	assign item.tag.frame_start = clr_pend_q;

	rbhs_update_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.dout       (dout)
	);

`ifndef NO_ASSERTIONS
	// column position stays inside the line buffers
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		column_pos_q <= CW'(MAX_WIDTH - 1))
		else $error("red_black_heat_stencil: column position out of range");

	// a cell in the last column wraps the position to column zero
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_col |=> column_pos_q == '0)
		else $error("red_black_heat_stencil: no wrap after last column");

	// the top-left cell of a frame arms the change-sum restart
	a_frame_arm: assert property (@(posedge clk) disable iff (!arst_n)
		accept && column_pos_q == '0 && row_pos_q == '0 |=> clr_pend_q)
		else $error("red_black_heat_stencil: frame restart not armed");
`endif

endmodule
